// File: src/lcd_capture_vga_upscaler_assert.svh
// Assertion macros shared by the scaler RTL.
// No dependencies; the using module must have clk and rst_n in scope.
`ifndef LCD_CAPTURE_VGA_UPSCALER_ASSERT_SVH
`define LCD_CAPTURE_VGA_UPSCALER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LCDVS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCDVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lcdvs_pkg.sv
// Shared constants, types and controller/datapath structs for the scaler.
// No dependencies.
package lcdvs_pkg;

  // Source frame and scale
  localparam int SRC_WIDTH  = 160;
  localparam int SRC_HEIGHT = 144;
  localparam int SCALE      = 3;

  // Screen geometry
  localparam int BORDER_LEFT  = 79;
  localparam int BORDER_RIGHT = 80;
  localparam int BORDER_TOP   = 24;
  localparam int GRID_PHASE   = 2;
  localparam int PIC_W        = SRC_WIDTH * SCALE;
  localparam int PIC_H        = SRC_HEIGHT * SCALE;
  localparam int PIC_X_END    = BORDER_LEFT + PIC_W;
  localparam int LINE_END     = PIC_X_END + BORDER_RIGHT;
  localparam int PIC_Y_END    = BORDER_TOP + PIC_H;
  localparam int TOP_MOD      = BORDER_TOP % SCALE;

  // Frame store
  localparam int STORE_SIZE = SRC_WIDTH * SRC_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int CNT_W      = $clog2(STORE_SIZE + 1);
  localparam int COL_W      = $clog2(SRC_WIDTH);
  localparam int ROW_W      = $clog2(SRC_HEIGHT);

  // Divide by SCALE: q = (v * RECIP) >> DIV_K, exact for v < 1024
  localparam int DIV_K  = 13;
  localparam int RECIP  = (2 ** DIV_K + SCALE - 1) / SCALE;
  localparam int RCP_W  = $clog2(RECIP + 1);

  // Field widths
  localparam int X_W       = 10;
  localparam int Y_W       = 9;
  localparam int GEO_W     = 12;
  localparam int COLOR_W   = 6;
  localparam int SHADE_W   = 2;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int REM_W     = 3;
  localparam int PROD_W    = X_W + RCP_W;

  typedef logic [X_W-1:0]       x_t;
  typedef logic [Y_W-1:0]       y_t;
  typedef logic [GEO_W-1:0]     geo_t;
  typedef logic [COLOR_W-1:0]   color_t;
  typedef logic [SHADE_W-1:0]   shade_t;
  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [REM_W-1:0]     rem_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [PROD_W-1:0]    prod_t;

  // Operation codes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_DISPLAY = 1'b1;

  // Register indexes
  localparam cfg_idx_t CFG_PAL0   = 3'd0;
  localparam cfg_idx_t CFG_PAL1   = 3'd1;
  localparam cfg_idx_t CFG_PAL2   = 3'd2;
  localparam cfg_idx_t CFG_PAL3   = 3'd3;
  localparam cfg_idx_t CFG_BORDER = 3'd4;
  localparam cfg_idx_t CFG_EFFECT = 3'd5;
  localparam cfg_idx_t CFG_MODE   = 3'd6;

  // Effect modes (mode three acts as none)
  localparam mode_t MODE_NONE = 2'd0;
  localparam mode_t MODE_GRID = 2'd1;
  localparam mode_t MODE_SCAN = 2'd2;

  // Register reset values
  localparam color_t RST_PAL0   = 6'd63;
  localparam color_t RST_PAL1   = 6'd42;
  localparam color_t RST_PAL2   = 6'd21;
  localparam color_t RST_PAL3   = 6'd0;
  localparam color_t RST_BORDER = 6'd0;
  localparam color_t RST_EFFECT = 6'd63;
  localparam color_t BLACK      = 6'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_OUT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept_cap;
    logic accept_disp;
    logic div_en;
    logic addr_en;
    logic rd_en;
    logic out_en;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic pic;
  } stat_t;

endpackage

// File: src/lcd_capture_vga_upscaler.sv
// Top level: LCD frame capture with 3x nearest-neighbor VGA readout.
// Depends on lcdvs_pkg, lcdvs_ctrl, lcdvs_dp and the assertion header.
//
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// in_      | start, busy (xfer: start  | in_operation, in_shade, in_frame_start,
//          |   high while busy low)    | in_screen_x, in_screen_y
// out_     | out_valid, 1-cycle strobe | out_pixel_color
// cfg_     | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// Capture transfers need no sequencing: the shade is written to the store on the
// accepting edge and busy stays low, so captures can run every cycle.
// Display transfers walk divide, address, store read and color select; the
// result register strobes after states DIV, ADDR, READ and OUT inside the
// picture, and after DIV and OUT in the border or black column. The next
// transfer is taken in the strobe cycle; only picture reads use the store.
// Reset is synchronous; the 23040-entry store is not cleared. A fill mark
// holds the highest captured address + 1 and reads at or above it show shade 0.
// The result strobe cannot be held off; cfg_ready is always high.
module lcd_capture_vga_upscaler (
  input  logic                       clk,
  input  logic                       rst_n,
  // item input
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  lcdvs_pkg::shade_t          in_shade,
  input  logic                       in_frame_start,
  input  lcdvs_pkg::x_t              in_screen_x,
  input  lcdvs_pkg::y_t              in_screen_y,
  // result output
  output logic                       out_valid,
  output lcdvs_pkg::color_t          out_pixel_color,
  // register writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  lcdvs_pkg::cfg_idx_t        cfg_index,
  input  lcdvs_pkg::color_t          cfg_data
);

  `include "lcd_capture_vga_upscaler_assert.svh"

  lcdvs_pkg::cmd_t  cmd;
  lcdvs_pkg::stat_t stat;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  lcdvs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .busy         (busy),
    .cmd          (cmd)
  );

  lcdvs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_shade        (in_shade),
    .in_frame_start  (in_frame_start),
    .in_screen_x     (in_screen_x),
    .in_screen_y     (in_screen_y),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_pixel_color (out_pixel_color)
  );

  // Display transfer starts the sequencer; capture leaves it idle.
  `LCDVS_ASSERT_NEXT(a_disp_busy, start && !busy && in_operation == lcdvs_pkg::OP_DISPLAY, busy, "display transfer did not raise busy")
  `LCDVS_ASSERT_NEXT(a_cap_idle, start && !busy && in_operation == lcdvs_pkg::OP_CAPTURE, !busy, "capture transfer raised busy")
  // One strobe per display item, shown while idle.
  `LCDVS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `LCDVS_ASSERT_IMPL(a_result_idle, out_valid, !busy, "result strobe while busy")

endmodule

// File: src/lcdvs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lcdvs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/lcdvs_ctrl.sv
// Sequencing state machine for display requests.
// Depends on lcdvs_pkg.
module lcdvs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_operation,
  input  lcdvs_pkg::stat_t  stat,
  output logic              busy,
  output lcdvs_pkg::cmd_t   cmd
);

  lcdvs_pkg::state_t state_r, state_nxt;
  logic              accept;

  assign accept = start && (state_r == lcdvs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcdvs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcdvs_pkg::ST_IDLE: begin
        if (accept && (in_operation == lcdvs_pkg::OP_DISPLAY)) begin
          state_nxt = lcdvs_pkg::ST_DIV;
        end
      end
      lcdvs_pkg::ST_DIV: begin
        // outside the picture no store read is needed
        state_nxt = stat.pic ? lcdvs_pkg::ST_ADDR : lcdvs_pkg::ST_OUT;
      end
      lcdvs_pkg::ST_ADDR: state_nxt = lcdvs_pkg::ST_READ;
      lcdvs_pkg::ST_READ: state_nxt = lcdvs_pkg::ST_OUT;
      lcdvs_pkg::ST_OUT:  state_nxt = lcdvs_pkg::ST_IDLE;
      default:            state_nxt = lcdvs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = (state_r != lcdvs_pkg::ST_IDLE);
    cmd.accept_cap  = accept && (in_operation == lcdvs_pkg::OP_CAPTURE);
    cmd.accept_disp = accept && (in_operation == lcdvs_pkg::OP_DISPLAY);
    cmd.div_en      = (state_r == lcdvs_pkg::ST_DIV);
    cmd.addr_en     = (state_r == lcdvs_pkg::ST_ADDR);
    cmd.rd_en       = (state_r == lcdvs_pkg::ST_READ);
    cmd.out_en      = (state_r == lcdvs_pkg::ST_OUT);
  end

endmodule

// File: src/lcdvs_dp.sv
// Datapath: config registers, capture write, coordinate divide, store read.
// Depends on lcdvs_pkg and lcdvs_ram.
module lcdvs_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lcdvs_pkg::cmd_t           cmd,
  output lcdvs_pkg::stat_t          stat,
  input  lcdvs_pkg::shade_t         in_shade,
  input  logic                      in_frame_start,
  input  lcdvs_pkg::x_t             in_screen_x,
  input  lcdvs_pkg::y_t             in_screen_y,
  input  logic                      cfg_we,
  input  lcdvs_pkg::cfg_idx_t       cfg_index,
  input  lcdvs_pkg::color_t         cfg_data,
  output logic                      out_valid,
  output lcdvs_pkg::color_t         out_pixel_color
);

  // Config registers
  lcdvs_pkg::color_t pal_r [4];
  lcdvs_pkg::color_t border_r;
  lcdvs_pkg::color_t effect_r;
  lcdvs_pkg::mode_t  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r[0] <= lcdvs_pkg::RST_PAL0;
      pal_r[1] <= lcdvs_pkg::RST_PAL1;
      pal_r[2] <= lcdvs_pkg::RST_PAL2;
      pal_r[3] <= lcdvs_pkg::RST_PAL3;
      border_r <= lcdvs_pkg::RST_BORDER;
      effect_r <= lcdvs_pkg::RST_EFFECT;
      mode_r   <= lcdvs_pkg::MODE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdvs_pkg::CFG_PAL0:   pal_r[0] <= cfg_data;
        lcdvs_pkg::CFG_PAL1:   pal_r[1] <= cfg_data;
        lcdvs_pkg::CFG_PAL2:   pal_r[2] <= cfg_data;
        lcdvs_pkg::CFG_PAL3:   pal_r[3] <= cfg_data;
        lcdvs_pkg::CFG_BORDER: border_r <= cfg_data;
        lcdvs_pkg::CFG_EFFECT: effect_r <= cfg_data;
        lcdvs_pkg::CFG_MODE:   mode_r   <= cfg_data[lcdvs_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture address and fill mark; entries at or above the mark read as shade 0
  lcdvs_pkg::cnt_t cap_addr_r, cap_addr_nxt;
  lcdvs_pkg::cnt_t fill_r, fill_nxt;
  lcdvs_pkg::cnt_t wr_addr;
  logic            wr_en;

  always_comb begin
    wr_addr      = in_frame_start ? '0 : cap_addr_r;
    wr_en        = cmd.accept_cap && (wr_addr < lcdvs_pkg::cnt_t'(lcdvs_pkg::STORE_SIZE));
    cap_addr_nxt = cap_addr_r;
    fill_nxt     = fill_r;
    if (wr_en) begin
      cap_addr_nxt = wr_addr + 1'b1;
      if (wr_addr >= fill_r) begin
        fill_nxt = wr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_addr_r <= '0;
      fill_r     <= '0;
    end else begin
      cap_addr_r <= cap_addr_nxt;
      fill_r     <= fill_nxt;
    end
  end

  // Request latch
  lcdvs_pkg::x_t x_r;
  lcdvs_pkg::y_t y_r;

  always_ff @(posedge clk) begin
    if (cmd.accept_disp) begin
      x_r <= in_screen_x;
      y_r <= in_screen_y;
    end
  end

  // Region decode and divide by SCALE
  logic          black, border_px;
  lcdvs_pkg::geo_t gx, gy;
  lcdvs_pkg::x_t p;
  lcdvs_pkg::y_t py;
  lcdvs_pkg::prod_t prod_x, prod_y;

  always_comb begin
    gx        = lcdvs_pkg::geo_t'(x_r);
    gy        = lcdvs_pkg::geo_t'(y_r);
    black     = gx >= lcdvs_pkg::geo_t'(lcdvs_pkg::LINE_END);
    border_px = !black &&
                ((gy < lcdvs_pkg::geo_t'(lcdvs_pkg::BORDER_TOP)) ||
                 (gy >= lcdvs_pkg::geo_t'(lcdvs_pkg::PIC_Y_END)) ||
                 (gx < lcdvs_pkg::geo_t'(lcdvs_pkg::BORDER_LEFT)) ||
                 (gx >= lcdvs_pkg::geo_t'(lcdvs_pkg::PIC_X_END)));
    stat.pic  = !black && !border_px;
    p         = x_r - lcdvs_pkg::x_t'(lcdvs_pkg::BORDER_LEFT);
    py        = y_r - lcdvs_pkg::y_t'(lcdvs_pkg::BORDER_TOP);
    prod_x    = lcdvs_pkg::prod_t'(p) * lcdvs_pkg::prod_t'(lcdvs_pkg::RECIP);
    prod_y    = lcdvs_pkg::prod_t'(py) * lcdvs_pkg::prod_t'(lcdvs_pkg::RECIP);
  end

  logic              black_r, border_r_px;
  lcdvs_pkg::x_t     p_r;
  lcdvs_pkg::y_t     py_r;
  lcdvs_pkg::col_t   qcol_r;
  lcdvs_pkg::row_t   qrow_r;

  always_ff @(posedge clk) begin
    if (cmd.div_en) begin
      black_r     <= black;
      border_r_px <= border_px;
      p_r         <= p;
      py_r        <= py;
      qcol_r      <= lcdvs_pkg::col_t'(prod_x >> lcdvs_pkg::DIV_K);
      qrow_r      <= lcdvs_pkg::row_t'(prod_y >> lcdvs_pkg::DIV_K);
    end
  end

  // Remainders, effects, store index
  lcdvs_pkg::rem_t  xrem, yrem, ymod;
  lcdvs_pkg::addr_t idx;

  always_comb begin
    xrem = lcdvs_pkg::rem_t'(lcdvs_pkg::geo_t'(p_r) -
           lcdvs_pkg::geo_t'(qcol_r) * lcdvs_pkg::geo_t'(lcdvs_pkg::SCALE));
    yrem = lcdvs_pkg::rem_t'(lcdvs_pkg::geo_t'(py_r) -
           lcdvs_pkg::geo_t'(qrow_r) * lcdvs_pkg::geo_t'(lcdvs_pkg::SCALE));
    // y mod SCALE from (y - top) mod SCALE
    ymod = yrem + lcdvs_pkg::rem_t'(lcdvs_pkg::TOP_MOD);
    if (ymod >= lcdvs_pkg::rem_t'(lcdvs_pkg::SCALE)) begin
      ymod = ymod - lcdvs_pkg::rem_t'(lcdvs_pkg::SCALE);
    end
    idx = lcdvs_pkg::addr_t'(lcdvs_pkg::addr_t'(qrow_r) *
          lcdvs_pkg::addr_t'(lcdvs_pkg::SRC_WIDTH) + lcdvs_pkg::addr_t'(qcol_r));
  end

  logic             scan_r, grid_r, hit_r;
  lcdvs_pkg::addr_t idx_r;

  always_ff @(posedge clk) begin
    if (cmd.addr_en) begin
      scan_r <= ((mode_r == lcdvs_pkg::MODE_GRID) || (mode_r == lcdvs_pkg::MODE_SCAN)) &&
                (ymod == '0);
      grid_r <= (mode_r == lcdvs_pkg::MODE_GRID) &&
                (xrem == lcdvs_pkg::rem_t'(lcdvs_pkg::GRID_PHASE));
      hit_r  <= lcdvs_pkg::cnt_t'(idx) < fill_r;
      idx_r  <= idx;
    end
  end

  // Frame store
  lcdvs_pkg::shade_t rd_shade;

  lcdvs_ram #(
    .WIDTH (lcdvs_pkg::SHADE_W),
    .DEPTH (lcdvs_pkg::STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr[lcdvs_pkg::ADDR_W-1:0]),
    .wdata (in_shade),
    .re    (cmd.rd_en),
    .raddr (idx_r),
    .rdata (rd_shade)
  );

  // Color select and result register
  lcdvs_pkg::color_t color;
  lcdvs_pkg::shade_t shade_eff;

  always_comb begin
    shade_eff = hit_r ? rd_shade : '0;
    if (black_r) begin
      color = lcdvs_pkg::BLACK;
    end else if (border_r_px) begin
      color = border_r;
    end else if (scan_r || grid_r) begin
      color = effect_r;
    end else begin
      color = pal_r[shade_eff];
    end
  end

  logic              out_valid_r;
  lcdvs_pkg::color_t out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_en) begin
      out_color_r <= color;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;

endmodule

// File: dv/tb_lcd_capture_vga_upscaler.sv
// Self-checking testbench for lcd_capture_vga_upscaler: capture and display transfers,
// register writes, and a bit-accurate model of frame store, geometry, palette and effects.
// Depends on lcdvs_pkg (port types, opcodes, register indexes, modes, reset colors).
module tb_lcd_capture_vga_upscaler;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdvs_pkg::*;

  // Geometry of the scaled picture on the VGA raster
  localparam int IMG_W      = 160;
  localparam int IMG_H      = 144;
  localparam int ZOOM       = 3;
  localparam int IMG_SIZE   = IMG_W * IMG_H;
  localparam int LEFT_COLS  = 79;
  localparam int RIGHT_COLS = 80;
  localparam int TOP_LINES  = 24;
  localparam int GRID_COL   = 2;
  localparam int PIC_COLS   = IMG_W * ZOOM;
  localparam int PIC_LINES  = IMG_H * ZOOM;
  localparam int PIC_RIGHT  = LEFT_COLS + PIC_COLS;
  localparam int PIC_BOTTOM = TOP_LINES + PIC_LINES;
  localparam int DARK_COL   = PIC_RIGHT + RIGHT_COLS;

  // Mode three is not defined and must behave like no effect
  localparam mode_t MODE_RSVD = 2'd3;
  localparam mode_t MODE_CYCLE [4] = '{MODE_NONE, MODE_GRID, MODE_SCAN, MODE_RSVD};

  // Columns and lines around every geometry boundary, plus the field maxima
  localparam int COL_MARKS  [9] = '{0, 78, 79, 80, 558, 559, 638, 639, 1023};
  localparam int LINE_MARKS [8] = '{0, 23, 24, 455, 456, 479, 480, 511};

  localparam int SETTLE_CYCLES   = 8;     // outlasts a display item's DIV, ADDR, READ, OUT path
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any transfer
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int PRELOAD_ITEMS   = IMG_W * 3;  // source rows 0 to 2

  // One line of the directed script: a register write or an input item
  typedef struct packed {
    logic     is_cfg;
    cfg_idx_t idx;
    color_t   data;
    logic     op;
    shade_t   sh;
    logic     fs;
    x_t       x;
    y_t       y;
    logic     typed;
    color_t   want;
  } step_row_t;

  // All inputs known from time zero
  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     in_operation = 1'b0;
  shade_t   in_shade = '0;
  logic     in_frame_start = 1'b0;
  x_t       in_screen_x = '0;
  y_t       in_screen_y = '0;
  logic     cfg_valid = 1'b0;
  cfg_idx_t cfg_index = '0;
  color_t   cfg_data = '0;

  logic     busy;
  logic     out_valid;
  color_t   out_pixel_color;
  logic     cfg_ready;

  // Hand-typed expectation travelling with the item it belongs to
  logic     want_typed = 1'b0;
  color_t   want_color = '0;

  // Model state; initializers are the reset state (reset is applied once)
  shade_t   frame_img [IMG_SIZE] = '{default: '0};
  int       cap_addr = 0;
  color_t   pal_reg [4] = '{RST_PAL0, RST_PAL1, RST_PAL2, RST_PAL3};
  color_t   border_reg = RST_BORDER;
  color_t   effect_reg = RST_EFFECT;
  mode_t    mode_reg = MODE_NONE;

  color_t   pending_colors [$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       sender_idles = 1'b1;

  always #5 clk = ~clk;

  lcd_capture_vga_upscaler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_shade        (in_shade),
    .in_frame_start  (in_frame_start),
    .in_screen_x     (in_screen_x),
    .in_screen_y     (in_screen_y),
    .out_valid       (out_valid),
    .out_pixel_color (out_pixel_color),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Color of one VGA pixel under the current registers and frame store.
  // Order matters: black column first, then border, then scanline, grid, palette.
  function automatic color_t screen_color(int x, int y);
    int p;
    int row;
    int col;
    if (x >= DARK_COL) return BLACK;
    if (y < TOP_LINES || y >= PIC_BOTTOM || x < LEFT_COLS || x >= PIC_RIGHT)
      return border_reg;
    p   = x - LEFT_COLS;
    row = (y - TOP_LINES) / ZOOM;
    col = p / ZOOM;
    // scanline phase follows the absolute line number, not the picture line
    if ((mode_reg == MODE_GRID || mode_reg == MODE_SCAN) && (y % ZOOM) == 0)
      return effect_reg;
    if (mode_reg == MODE_GRID && (p % ZOOM) == GRID_COL)
      return effect_reg;
    return pal_reg[frame_img[row * IMG_W + col]];
  endfunction

  // Capture: optional restart, then write unless the frame is already full
  function automatic void store_shade(shade_t sh, logic fs);
    if (fs) cap_addr = 0;
    if (cap_addr < IMG_SIZE) begin
      frame_img[cap_addr] = sh;
      cap_addr++;
    end
  endfunction

  // Monitor: everything is sampled at the rising edge, before the block's own
  // updates land, so transfers are seen exactly as the block sees them.
  always @(posedge clk) begin : monitor
    logic moved;
    color_t exp_c;
    if (rst_n) begin
      moved = 1'b0;

      // register write transfer
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_PAL0:   pal_reg[0] = cfg_data;
          CFG_PAL1:   pal_reg[1] = cfg_data;
          CFG_PAL2:   pal_reg[2] = cfg_data;
          CFG_PAL3:   pal_reg[3] = cfg_data;
          CFG_BORDER: border_reg = cfg_data;
          CFG_EFFECT: effect_reg = cfg_data;
          CFG_MODE:   mode_reg = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end

      // result strobe: check before queuing any item taken on this same edge
      if (out_valid === 1'b1) begin
        moved = 1'b1;
        if (pending_colors.size() == 0) begin
          $error("pixel_color: unexpected result %0d, nothing pending", out_pixel_color);
          errors++;
        end else begin
          exp_c = pending_colors.pop_front();
          if (out_pixel_color !== exp_c) begin
            $error("pixel_color: expected %0d, actual %0d", exp_c, out_pixel_color);
            errors++;
          end
        end
      end

      // input transfer
      if (start && busy === 1'b0) begin
        moved = 1'b1;
        if (in_operation == OP_CAPTURE)
          store_shade(in_shade, in_frame_start);
        else if (want_typed)
          pending_colors.push_back(want_color);
        else
          pending_colors.push_back(screen_color(in_screen_x, in_screen_y));
      end

      if (moved) idle_cycles = 0;
      else       idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Present one item and hold it until the transfer edge. start is left high;
  // the caller lowers it only when a gap or a pause follows.
  task automatic send_item(logic op, shade_t sh, logic fs, x_t x, y_t y,
                           logic typed, color_t want);
    start          <= 1'b1;
    in_operation   <= op;
    in_shade       <= sh;
    in_frame_start <= fs;
    in_screen_x    <= x;
    in_screen_y    <= y;
    want_typed     <= typed;
    want_color     <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Random idle burst on the sending side
  task automatic sender_gap();
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Drain: no new items, wait for every pending color, then cover a display
  // item that may still be in flight behind a run of captures.
  task automatic settle();
    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_valid is left high so back-to-back writes need no toggle
  task automatic write_reg(cfg_idx_t idx, color_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Random item: mostly picture reads (often in the rows captures rewrite),
  // some anywhere in the field range, some right on the boundaries.
  task automatic random_item();
    int   sel;
    x_t   x;
    y_t   y;
    logic op;
    op  = ($urandom_range(0, 99) < 35) ? OP_CAPTURE : OP_DISPLAY;
    sel = $urandom_range(0, 19);
    if (sel < 12) begin
      x = x_t'($urandom_range(LEFT_COLS, PIC_RIGHT - 1));
      if (sel < 5) y = y_t'($urandom_range(TOP_LINES, TOP_LINES + 3 * ZOOM - 1));
      else         y = y_t'($urandom_range(TOP_LINES, PIC_BOTTOM - 1));
    end else if (sel < 17) begin
      x = x_t'($urandom_range(0, 1023));
      y = y_t'($urandom_range(0, 511));
    end else begin
      x = x_t'(COL_MARKS[$urandom_range(0, 8)]);
      y = y_t'(LINE_MARKS[$urandom_range(0, 7)]);
    end
    send_item(op, shade_t'($urandom_range(0, 3)), ($urandom_range(0, 79) == 0),
              x, y, 1'b0, '0);
  endtask

  function automatic step_row_t cfg_row(cfg_idx_t idx, color_t data);
    step_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic step_row_t disp_row(int x, int y, logic typed, color_t want);
    step_row_t r;
    r       = '0;
    r.op    = OP_DISPLAY;
    r.x     = x_t'(x);
    r.y     = y_t'(y);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic step_row_t cap_row(logic fs, shade_t sh);
    step_row_t r;
    r    = '0;
    r.op = OP_CAPTURE;
    r.fs = fs;
    r.sh = sh;
    return r;
  endfunction

  initial begin : stimulus
    step_row_t script [$];
    bit        in_cfg;
    color_t    setting [6];
    color_t    mode_word;

    in_cfg = 1'b0;

    // Reset state: border black, empty store reads palette entry 0 (63)
    script.push_back(disp_row(0, 0, 1, 6'd0));
    script.push_back(disp_row(639, 479, 1, 6'd0));
    script.push_back(disp_row(79, 24, 1, 6'd63));
    script.push_back(disp_row(558, 455, 1, 6'd63));
    script.push_back(disp_row(1023, 511, 1, 6'd0));
    // Border and frame edges with a visible border color
    script.push_back(cfg_row(CFG_BORDER, 6'd12));
    script.push_back(cfg_row(CFG_PAL3, 6'd33));
    script.push_back(cfg_row(CFG_EFFECT, 6'd50));
    script.push_back(disp_row(0, 0, 1, 6'd12));
    script.push_back(disp_row(78, 300, 1, 6'd12));
    script.push_back(disp_row(559, 300, 1, 6'd12));
    script.push_back(disp_row(638, 479, 1, 6'd12));
    script.push_back(disp_row(200, 480, 1, 6'd12));   // past the last screen line
    script.push_back(disp_row(639, 200, 1, 6'd0));    // last column is always black
    // Restart the frame and lay down shades 3, 2, 1 on source row 0
    script.push_back(cap_row(1'b1, 2'd3));
    script.push_back(cap_row(1'b0, 2'd2));
    script.push_back(cap_row(1'b0, 2'd1));
    script.push_back(disp_row(81, 26, 1, 6'd33));
    script.push_back(disp_row(82, 24, 1, 6'd21));
    script.push_back(disp_row(85, 24, 1, 6'd42));
    script.push_back(disp_row(88, 27, 0, '0));
    // Grid plus scanlines: scanline on line 24, grid column at p = 2
    script.push_back(cfg_row(CFG_MODE, color_t'(MODE_GRID)));
    script.push_back(disp_row(79, 24, 1, 6'd50));
    script.push_back(disp_row(81, 25, 1, 6'd50));
    script.push_back(disp_row(80, 25, 1, 6'd33));
    script.push_back(disp_row(0, 24, 1, 6'd12));     // effects never touch the border
    // Scanlines only: grid column shows the picture again
    script.push_back(cfg_row(CFG_MODE, color_t'(MODE_SCAN)));
    script.push_back(disp_row(81, 25, 1, 6'd33));
    script.push_back(disp_row(100, 27, 1, 6'd50));
    // Undefined mode three acts as no effect
    script.push_back(cfg_row(CFG_MODE, color_t'(MODE_RSVD)));
    script.push_back(disp_row(79, 24, 1, 6'd33));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk; register rows are grouped and preceded by a drain
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        if (!in_cfg) begin
          settle();
          in_cfg = 1'b1;
        end
        write_reg(script[i].idx, script[i].data);
      end else begin
        if (in_cfg) begin
          cfg_valid <= 1'b0;
          in_cfg = 1'b0;
        end
        send_item(script[i].op, script[i].sh, script[i].fs, script[i].x, script[i].y,
                  script[i].typed, script[i].want);
        sender_gap();
      end
    end

    // Random phases, each under its own register setting. The first two use
    // the color extremes; modes rotate through all four codes.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       setting = '{6'd0, 6'd63, 6'd0, 6'd63, 6'd63, 6'd0};
        1:       setting = '{6'd63, 6'd0, 6'd63, 6'd0, 6'd0, 6'd63};
        default: foreach (setting[r]) setting[r] = color_t'($urandom_range(0, 63));
      endcase
      // upper data bits are don't-care for the mode register
      mode_word = (ph < 2) ? color_t'(0) : color_t'($urandom_range(0, 63));
      mode_word[MODE_W-1:0] = MODE_CYCLE[ph % 4];
      write_reg(CFG_PAL0, setting[0]);
      write_reg(CFG_PAL1, setting[1]);
      write_reg(CFG_PAL2, setting[2]);
      write_reg(CFG_PAL3, setting[3]);
      write_reg(CFG_BORDER, setting[4]);
      write_reg(CFG_EFFECT, setting[5]);
      write_reg(CFG_MODE, mode_word);
      cfg_valid <= 1'b0;

      // Frame restart and three source rows of random shades; the random
      // reads favor these rows, so they see varied content.
      if (ph == 0) begin
        sender_idles = 1'b1;
        for (int k = 0; k < PRELOAD_ITEMS; k++) begin
          send_item(OP_CAPTURE, shade_t'($urandom_range(0, 3)), (k == 0),
                    '0, '0, 1'b0, '0);
          sender_gap();
        end
      end

      // Idling comes and goes in stretches; the last phase runs flat out
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 32 == 0)
          sender_idles = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
        random_item();
        sender_gap();
      end
    end

    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
